// File: hdl/hbd_pkg.sv
package hbd_pkg;

    localparam int MAX_CODE_LEN = 16;
    localparam int TABLE_SLOTS  = 256;

    localparam int KIND_W    = 2;
    localparam int SLOT_IN_W = 8;
    localparam int CODE_W    = 16;
    localparam int LEN_W     = 5;
    localparam int SYM_W     = 8;

    localparam int ACC_W  = MAX_CODE_LEN;
    localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CMP_W  = (ACC_W > CODE_W) ? ACC_W : CODE_W;
    localparam int LCMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_DECODE = 2'd1,
        KIND_START  = 2'd2
    } t_kind;

    typedef enum logic {
        STAT_OK       = 1'b0,
        STAT_TOO_LONG = 1'b1
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [SYM_W-1:0]  sym;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_entry            entry;
    } t_wr_req;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [SYM_W-1:0] symbol;
    } t_scan_res;

endpackage

// File: hdl/hbd_slot_table.sv
module hbd_slot_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  hbd_pkg::t_wr_req         i_wr,
    input  logic                     i_clear,
    input  logic                     i_scan_start,
    input  logic [hbd_pkg::ACC_W-1:0] i_key_bits,
    input  logic [hbd_pkg::CNT_W-1:0] i_key_count,
    output hbd_pkg::t_scan_res       o_res
);
    import hbd_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    t_entry             r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;

    logic               r_scan_on;
    logic [SLOT_W-1:0]  r_addr;
    logic               r_rd_pend;
    logic               r_rd_last;
    logic               r_rd_valid;
    t_entry             r_rd_entry;

    logic [CMP_W-1:0]   mask;
    logic               match;
    logic               done;

    // valid marks: start wipes them all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clear) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_entry <= r_mem[r_addr];
        r_rd_valid <= r_valid[r_addr];
        r_rd_last  <= (r_addr == LAST_SLOT);
    end

    // walk slots from lowest; first hit stops the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on <= 1'b0;
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= r_scan_on && !done;
            if (i_scan_start) begin
                r_scan_on <= 1'b1;
                r_addr    <= '0;
            end else if (r_scan_on) begin
                if (done || r_addr == LAST_SLOT) begin
                    r_scan_on <= 1'b0;
                end else begin
                    r_addr <= r_addr + SLOT_W'(1);
                end
            end
        end
    end

    always_comb begin
        mask  = (CMP_W'(1) << i_key_count) - CMP_W'(1);
        match = r_rd_valid
             && (r_rd_entry.len != '0)
             && (LCMP_W'(r_rd_entry.len) == LCMP_W'(i_key_count))
             && ((CMP_W'(r_rd_entry.code) & mask) == CMP_W'(i_key_bits));
        done  = r_rd_pend && (match || r_rd_last);
        o_res.done   = done;
        o_res.hit    = r_rd_pend && match;
        o_res.symbol = r_rd_entry.sym;
    end

endmodule

// File: hdl/huffman_bit_decoder_core.sv
// Load and start transactions never stall the input; o_in_ready stays high.
// A decode transaction walks the slot table one slot per cycle from slot 0;
// a hit or a too-long accumulator gives a result in the output register. No
// new item is accepted until the walk ends and that result is loaded (later if the output stalls).
// Synchronous active-low reset clears accumulator, stuck flag, valid marks
// and the output valid flag; slot contents are left as they were.
module huffman_bit_decoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [hbd_pkg::KIND_W-1:0]    i_kind,
    input  logic                          i_bit_req,
    input  logic [hbd_pkg::SLOT_IN_W-1:0] i_entry_slot,
    input  logic [hbd_pkg::CODE_W-1:0]    i_entry_code,
    input  logic [hbd_pkg::LEN_W-1:0]     i_entry_length,
    input  logic [hbd_pkg::SYM_W-1:0]     i_entry_symbol,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hbd_pkg::SYM_W-1:0]     o_symbol,
    output logic                          o_status
);
    import hbd_pkg::*;

    t_state             r_state, n_state;
    logic [ACC_W-1:0]   r_acc_bits;
    logic [CNT_W-1:0]   r_acc_count;
    logic               r_stuck;
    logic               r_out_valid;
    logic [SYM_W-1:0]   r_out_symbol;
    logic               r_out_status;
    logic [SYM_W-1:0]   r_res_symbol;
    logic               r_res_status;

    logic               accept;
    logic               is_load, is_decode, is_start;
    logic               scan_start;
    logic               out_free;
    logic               too_long;
    logic               res_any;
    logic [SYM_W-1:0]   res_symbol;
    logic               res_status;
    logic               out_load;
    t_wr_req            wr;
    t_scan_res          scan;

    assign accept    = i_in_valid && o_in_ready;
    assign is_load   = (i_kind == KIND_LOAD);
    assign is_decode = (i_kind == KIND_DECODE);
    assign is_start  = (i_kind == KIND_START);
    assign out_free  = !r_out_valid || i_out_ready;
    assign too_long  = (r_acc_count >= CNT_W'(MAX_CODE_LEN));

    always_comb begin
        wr.en          = accept && is_load
                      && ({1'b0, i_entry_slot} < (SLOT_IN_W + 1)'(TABLE_SLOTS));
        wr.addr        = SLOT_W'(i_entry_slot);
        wr.entry.code  = i_entry_code;
        wr.entry.len   = i_entry_length;
        wr.entry.sym   = i_entry_symbol;
    end

    hbd_slot_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (wr),
        .i_clear      (accept && is_start),
        .i_scan_start (scan_start),
        .i_key_bits   (r_acc_bits),
        .i_key_count  (r_acc_count),
        .o_res        (scan)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_decode && !r_stuck) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan.done) begin
                    if (res_any && !out_free) begin
                        n_state = ST_WAIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        scan_start = 1'b0;
        out_load   = 1'b0;
        res_any    = scan.hit || too_long;
        res_symbol = scan.hit ? scan.symbol : '0;
        res_status = scan.hit ? STAT_OK : STAT_TOO_LONG;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                scan_start = accept && is_decode && !r_stuck;
            end
            ST_SCAN: begin
                out_load = scan.done && res_any && out_free;
            end
            ST_WAIT: begin
                out_load   = out_free;
                res_symbol = r_res_symbol;
                res_status = r_res_status;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc_bits  <= '0;
            r_acc_count <= '0;
            r_stuck     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && is_start) begin
                r_acc_bits  <= '0;
                r_acc_count <= '0;
                r_stuck     <= 1'b0;
            end else if (scan_start) begin
                r_acc_bits  <= {r_acc_bits[ACC_W-2:0], i_bit_req};
                r_acc_count <= r_acc_count + CNT_W'(1);
            end else if (r_state == ST_SCAN && scan.done && res_any) begin
                r_acc_bits  <= '0;
                r_acc_count <= '0;
                if (!scan.hit) begin
                    r_stuck <= 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && scan.done) begin
            r_res_symbol <= res_symbol;
            r_res_status <= res_status;
        end
        if (out_load) begin
            r_out_symbol <= res_symbol;
            r_out_status <= res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_out_symbol;
    assign o_status    = r_out_status;

endmodule

// File: hdl/hbd_checker.sv
module hbd_port_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [hbd_pkg::KIND_W-1:0]    i_kind,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [hbd_pkg::SYM_W-1:0]     o_symbol,
    input logic                          o_status
);
    import hbd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_symbol) && $stable(o_status))
        else $error("result changed while stalled");

    a_err_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STAT_TOO_LONG |-> o_symbol == '0)
        else $error("error result carries nonzero symbol");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // table writes, stream starts and unused kinds never stall the input side
    a_fast_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_kind != KIND_DECODE |=> o_in_ready)
        else $error("input stalled after load or start");

    // a decode needs at least one table read before any result
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_kind == KIND_DECODE |=> !$rose(o_out_valid))
        else $error("result one cycle after decode transaction");

endmodule

bind huffman_bit_decoder_core hbd_port_checker u_hbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_kind      (i_kind),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_symbol    (o_symbol),
    .o_status    (o_status)
);

// File: verif/hbd_checker.sv
module hbd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [hbd_pkg::KIND_W-1:0]    i_kind,
    input  logic                          i_bit_req,
    input  logic [hbd_pkg::SLOT_IN_W-1:0] i_entry_slot,
    input  logic [hbd_pkg::CODE_W-1:0]    i_entry_code,
    input  logic [hbd_pkg::LEN_W-1:0]     i_entry_length,
    input  logic [hbd_pkg::SYM_W-1:0]     i_entry_symbol,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [hbd_pkg::SYM_W-1:0]     i_symbol,
    input  logic                          i_status,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import hbd_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        t_status          status;
    } t_decoded;

    t_decoded          symbols_due[$];

    logic [CODE_W-1:0] tab_code [TABLE_SLOTS];
    logic [LEN_W-1:0]  tab_len  [TABLE_SLOTS];
    logic [SYM_W-1:0]  tab_sym  [TABLE_SLOTS];
    logic              tab_live [TABLE_SLOTS];

    logic [ACC_W-1:0]  acc_bits;
    int                acc_len;
    logic              halted;
    int                n_results;

    task automatic log_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // start transaction and reset: table contents survive, valid marks do not
    task automatic clear_stream();
        acc_bits = '0;
        acc_len  = 0;
        halted   = 1'b0;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            tab_live[s] = 1'b0;
        end
    endtask

    task automatic shift_in_bit(input logic b);
        int          hit;
        int          s;
        logic [31:0] mask;
        t_decoded    res;
        if (halted) begin
            return;
        end
        acc_bits = {acc_bits[ACC_W-2:0], b};
        acc_len++;
        hit = -1;
        for (s = 0; s < TABLE_SLOTS && hit < 0; s++) begin
            if (tab_live[s] && tab_len[s] != '0 && int'(tab_len[s]) == acc_len) begin
                mask = (32'd1 << tab_len[s]) - 32'd1;
                if ((32'(tab_code[s]) & mask) == 32'(acc_bits)) begin
                    hit = s;
                end
            end
        end
        if (hit >= 0) begin
            res.symbol = tab_sym[hit];
            res.status = STAT_OK;
            symbols_due = {symbols_due, res};
            acc_bits = '0;
            acc_len  = 0;
        end else if (acc_len >= MAX_CODE_LEN) begin
            // no code fits: one error, then silent until the next start
            res.symbol = '0;
            res.status = STAT_TOO_LONG;
            symbols_due = {symbols_due, res};
            acc_bits = '0;
            acc_len  = 0;
            halted   = 1'b1;
        end
    endtask

    task automatic check_result();
        t_decoded want;
        n_results++;
        if (symbols_due.size() == 0) begin
            log_failure($sformatf("result %0d: unexpected, symbol %02h status %0d",
                                  n_results, i_symbol, i_status));
        end else begin
            want = symbols_due.pop_front();
            if (i_symbol !== want.symbol || i_status !== want.status) begin
                log_failure($sformatf(
                    "result %0d: symbol exp %02h got %02h, status exp %0d got %0d",
                    n_results, want.symbol, i_symbol, want.status, i_status));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_stream();
            symbols_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && i_in_ready) begin
                case (i_kind)
                    KIND_LOAD: begin
                        if (int'(i_entry_slot) < TABLE_SLOTS) begin
                            tab_code[i_entry_slot] = i_entry_code;
                            tab_len[i_entry_slot]  = i_entry_length;
                            tab_sym[i_entry_slot]  = i_entry_symbol;
                            tab_live[i_entry_slot] = 1'b1;
                        end
                    end
                    KIND_DECODE: shift_in_bit(i_bit_req);
                    KIND_START:  clear_stream();
                    default: ;
                endcase
            end
        end
        o_pending <= symbols_due.size();
    end

endmodule

// File: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hbd_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 17;
    localparam int ITEM_TARGET = 1020;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic [KIND_W-1:0]    i_kind         = KIND_START;
    logic                 i_bit_req      = 1'b0;
    logic [SLOT_IN_W-1:0] i_entry_slot   = '0;
    logic [CODE_W-1:0]    i_entry_code   = '0;
    logic [LEN_W-1:0]     i_entry_length = '0;
    logic [SYM_W-1:0]     i_entry_symbol = '0;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic [SYM_W-1:0]     o_symbol;
    logic                 o_status;

    int decode_errors;
    int results_owed;
    int items_sent = 0;
    int cycle_no   = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    huffman_bit_decoder_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_bit_req      (i_bit_req),
        .i_entry_slot   (i_entry_slot),
        .i_entry_code   (i_entry_code),
        .i_entry_length (i_entry_length),
        .i_entry_symbol (i_entry_symbol),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_symbol       (o_symbol),
        .o_status       (o_status)
    );

    hbd_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_bit_req      (i_bit_req),
        .i_entry_slot   (i_entry_slot),
        .i_entry_code   (i_entry_code),
        .i_entry_length (i_entry_length),
        .i_entry_symbol (i_entry_symbol),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_symbol       (o_symbol),
        .i_status       (o_status),
        .o_fail_count   (decode_errors),
        .o_pending      (results_owed)
    );

    // output side stalls at random, except for one long stretch
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no >= 100000 && cycle_no < 150000) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_item(input logic [KIND_W-1:0]    kind,
                             input logic                 b,
                             input logic [SLOT_IN_W-1:0] slot,
                             input logic [CODE_W-1:0]    code,
                             input logic [LEN_W-1:0]     len,
                             input logic [SYM_W-1:0]     sym);
        while (!(items_sent >= 400 && items_sent < 550) && $urandom_range(99) < IDLE_PCT)
        begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_bit_req      <= b;
        i_entry_slot   <= slot;
        i_entry_code   <= code;
        i_entry_length <= len;
        i_entry_symbol <= sym;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        if (kind != KIND_UNUSED) begin
            items_sent++;
        end
    endtask

    // decode/start/unused transaction with junk in the table fields
    task automatic send_ctrl(input logic [KIND_W-1:0] kind, input logic b);
        send_item(kind, b, SLOT_IN_W'($urandom), CODE_W'($urandom),
                  LEN_W'($urandom), SYM_W'($urandom));
    endtask

    task automatic split_leaf(ref logic [CODE_W-1:0] codes[$], ref int lens[$],
                              input int idx);
        codes = {codes, CODE_W'({codes[idx], 1'b1})};
        lens  = {lens, lens[idx] + 1};
        codes[idx] = CODE_W'({codes[idx], 1'b0});
        lens[idx]  = lens[idx] + 1;
    endtask

    // one stream: a random prefix code (sometimes with a hole), loaded into
    // random slots, then a bit stream made mostly of its code words
    task automatic run_stream();
        logic [CODE_W-1:0] leaf_code[$];
        int                leaf_len[$];
        int                leaf_slot[$];
        logic [SYM_W-1:0]  leaf_sym[$];
        bit                slot_taken[int];
        int                n_split;
        int                pick;
        int                dropped;
        int                n_sym;
        int                s;
        logic [CODE_W-1:0] mask;

        if ($urandom_range(7) != 0) begin
            send_ctrl(KIND_START, 1'($urandom));
        end
        leaf_code = {leaf_code, CODE_W'(0)};
        leaf_len  = {leaf_len, 32'sd0};
        n_split = $urandom_range(11, 1);
        for (int i = 0; i < n_split; i++) begin
            pick = $urandom_range(leaf_code.size() - 1);
            if (leaf_len[pick] < MAX_CODE_LEN) begin
                split_leaf(leaf_code, leaf_len, pick);
            end
        end
        if ($urandom_range(5) == 0) begin
            pick = $urandom_range(leaf_code.size() - 1);
            while (leaf_len[pick] < MAX_CODE_LEN) begin
                split_leaf(leaf_code, leaf_len, pick);
            end
        end
        dropped = ($urandom_range(2) == 0) ? $urandom_range(leaf_code.size() - 1) : -1;

        for (int i = 0; i < leaf_code.size(); i++) begin
            do begin
                s = $urandom_range(TABLE_SLOTS - 1);
            end while (slot_taken.exists(s));
            slot_taken[s] = 1'b1;
            leaf_slot = {leaf_slot, s};
            leaf_sym  = {leaf_sym, SYM_W'($urandom)};
            if (i != dropped) begin
                mask = CODE_W'((32'd1 << leaf_len[i]) - 32'd1);
                send_item(KIND_LOAD, 1'($urandom), SLOT_IN_W'(s),
                          (leaf_code[i] & mask) | (CODE_W'($urandom) & ~mask),
                          LEN_W'(leaf_len[i]), leaf_sym[i]);
            end
        end

        n_sym = $urandom_range(16, 3);
        for (int k = 0; k < n_sym; k++) begin
            if ($urandom_range(14) == 0) begin
                case ($urandom_range(2))
                    0: send_item(KIND_LOAD, 1'($urandom), SLOT_IN_W'($urandom),
                                 CODE_W'($urandom), LEN_W'($urandom_range(16)),
                                 SYM_W'($urandom));
                    1: send_ctrl(KIND_UNUSED, 1'($urandom));
                    default: send_ctrl(KIND_START, 1'($urandom));
                endcase
            end else begin
                pick = $urandom_range(leaf_code.size() - 1);
                for (int b = leaf_len[pick] - 1; b >= 0; b--) begin
                    send_ctrl(KIND_DECODE, leaf_code[pick][b]);
                end
            end
        end
        // random trailing bits, possibly an incomplete code
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) send_ctrl(KIND_DECODE, 1'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_ctrl(KIND_START, 1'b0);
        // "0" with junk above the length, "11" at the top slot
        send_item(KIND_LOAD, 1'b1, 8'd0, 16'hFFFE, 5'd1, 8'h00);
        send_item(KIND_LOAD, 1'b0, 8'd255, 16'h0003, 5'd2, 8'hFF);
        // zero length and overlong length never match
        send_item(KIND_LOAD, 1'b0, 8'd9, 16'h0000, 5'd0, 8'hAA);
        send_item(KIND_LOAD, 1'b0, 8'd10, 16'h0001, 5'd31, 8'h55);
        send_ctrl(KIND_UNUSED, 1'b1);
        send_ctrl(KIND_DECODE, 1'b0);
        send_ctrl(KIND_DECODE, 1'b1);
        // load between bits of one code: accumulator is kept
        send_item(KIND_LOAD, 1'b1, 8'd4, 16'h0002, 5'd2, 8'h3C);
        send_ctrl(KIND_DECODE, 1'b0);
        // duplicate of "11" in a lower slot takes precedence
        send_item(KIND_LOAD, 1'b0, 8'd2, 16'hFFF3, 5'd2, 8'h77);
        send_ctrl(KIND_DECODE, 1'b1);
        send_ctrl(KIND_DECODE, 1'b1);
        send_ctrl(KIND_DECODE, 1'b1);
        // start drops the trailing bit and all valid marks
        send_ctrl(KIND_START, 1'b1);
        send_ctrl(KIND_DECODE, 1'b0);
        send_item(KIND_LOAD, 1'b0, 8'd0, 16'h0000, 5'd2, 8'h5A);
        send_ctrl(KIND_DECODE, 1'b0);
        send_ctrl(KIND_START, 1'b0);

        while (items_sent < ITEM_TARGET) begin
            run_stream();
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (results_owed != 0) begin
            @(posedge i_clk);
        end
        repeat (TABLE_SLOTS + 8) @(posedge i_clk);
        if (decode_errors == 0 && results_owed == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
